// File: rtl/fdcmp_pkg.sv
// shared types and constants for the factorial divisor count block
package fdcmp_pkg;

    localparam int          DEFAULT_MAX_N = 65535;
    localparam int          N_W           = 16;
    localparam int          RES_W         = 30;
    localparam logic [29:0] MODULUS       = 30'd1000000007;

    typedef struct packed {
        logic clr_step;
        logic sv_rd;
        logic sv_inc_i;
        logic sv_load_j;
        logic sv_mark;
        logic it_load;
        logic p_rd;
        logic p_inc;
        logic exp_init;
        logic div_load;
        logic div_step;
        logic exp_add;
        logic mul_load;
        logic mul_step;
        logic res_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic sv_done;
        logic flag;
        logic j_over;
        logic p_over;
        logic div_last;
        logic m_zero;
        logic mul_last;
    } status_t;

endpackage

// File: rtl/fdcmp_ctrl.sv
// sequencing state machine for the factorial divisor count block
module fdcmp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  fdcmp_pkg::status_t status,
    output fdcmp_pkg::cmd_t    cmd
);
    import fdcmp_pkg::*;

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_SV_RD   = 4'd1;
    localparam logic [3:0] S_SV_CHK  = 4'd2;
    localparam logic [3:0] S_SV_MARK = 4'd3;
    localparam logic [3:0] S_IDLE    = 4'd4;
    localparam logic [3:0] S_P_RD    = 4'd5;
    localparam logic [3:0] S_P_CHK   = 4'd6;
    localparam logic [3:0] S_DIV_LD  = 4'd7;
    localparam logic [3:0] S_DIV     = 4'd8;
    localparam logic [3:0] S_ACC     = 4'd9;
    localparam logic [3:0] S_MUL_LD  = 4'd10;
    localparam logic [3:0] S_MUL     = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_SV_RD;
                end
            end
            S_SV_RD:
            begin
                if (status.sv_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.sv_rd  = 1'b1;
                    state_next = S_SV_CHK;
                end
            end
            S_SV_CHK:
            begin
                if (status.flag)
                begin
                    cmd.sv_inc_i = 1'b1;
                    state_next   = S_SV_RD;
                end
                else
                begin
                    cmd.sv_load_j = 1'b1;
                    state_next    = S_SV_MARK;
                end
            end
            S_SV_MARK:
            begin
                if (status.j_over)
                begin
                    cmd.sv_inc_i = 1'b1;
                    state_next   = S_SV_RD;
                end
                else
                begin
                    cmd.sv_mark = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.it_load = 1'b1;
                    state_next  = S_P_RD;
                end
            end
            S_P_RD:
            begin
                if (status.p_over)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.p_rd   = 1'b1;
                    state_next = S_P_CHK;
                end
            end
            S_P_CHK:
            begin
                if (status.flag)
                begin
                    cmd.p_inc  = 1'b1;
                    state_next = S_P_RD;
                end
                else
                begin
                    cmd.exp_init = 1'b1;
                    state_next   = S_DIV_LD;
                end
            end
            S_DIV_LD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (status.m_zero)
                begin
                    state_next = S_MUL_LD;
                end
                else
                begin
                    cmd.exp_add = 1'b1;
                    state_next  = S_DIV_LD;
                end
            end
            S_MUL_LD:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (status.mul_last)
                begin
                    cmd.p_inc  = 1'b1;
                    state_next = S_P_RD;
                end
            end
            S_DONE:
            begin
                cmd.res_load = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

endmodule

// File: rtl/fdcmp_dp.sv
// datapath: composite flag memory, sieve counters, divider and modular multiplier
module fdcmp_dp #(
    parameter int MAX_N = fdcmp_pkg::DEFAULT_MAX_N
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fdcmp_pkg::cmd_t              cmd,
    output fdcmp_pkg::status_t           status,
    input  logic [fdcmp_pkg::N_W-1:0]    n_value,
    output logic                         done,
    output logic [fdcmp_pkg::RES_W-1:0]  divisor_count
);
    import fdcmp_pkg::*;

    localparam int ADDR_W = $clog2(MAX_N + 1);
    localparam int CNT_W  = (ADDR_W + 1 > 17) ? ADDR_W + 1 : 17;
    localparam int RW     = CNT_W + 1;
    localparam logic [CNT_W-1:0]   MAX_C  = CNT_W'(MAX_N);
    localparam logic [2*CNT_W-1:0] MAX_SQ = (2*CNT_W)'(MAX_N);

    // composite flags, 1 = composite
    logic mem [0:MAX_N];
    logic rd_data_reg;

    logic [CNT_W-1:0] clr_cnt_reg, i_reg, j_reg, p_reg, limit_reg;
    logic [N_W-1:0]   n_reg, m_reg, exp_reg;
    logic [RW-1:0]    rem_reg;
    logic [3:0]       div_cnt_reg, bit_reg;
    logic [RES_W-1:0] prod_reg, acc_reg;
    logic [RES_W-1:0] count_reg;
    logic             done_reg;

    logic [2*CNT_W-1:0] sq;
    logic [CNT_W-1:0]   n_ext, rd_addr, wr_addr;
    logic               we, wd;
    logic [RW-1:0]      rem_sh, p_ext;
    logic               ge;
    logic [RES_W:0]     dbl, dbl_red, add_sum;
    logic [RES_W-1:0]   acc_next;

    assign sq    = i_reg * i_reg;
    assign n_ext = CNT_W'(n_value);

    assign rd_addr = cmd.p_rd ? p_reg : i_reg;
    assign we      = cmd.clr_step | cmd.sv_mark;
    assign wr_addr = cmd.clr_step ? clr_cnt_reg : j_reg;
    assign wd      = cmd.sv_mark;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr[ADDR_W-1:0]] <= wd;
        end
        if (cmd.sv_rd || cmd.p_rd)
        begin
            rd_data_reg <= mem[rd_addr[ADDR_W-1:0]];
        end
    end

    // restoring divide step, one quotient bit a cycle
    assign rem_sh = {rem_reg[RW-2:0], m_reg[N_W-1]};
    assign p_ext  = RW'(p_reg);
    assign ge     = (rem_sh >= p_ext);

    // shift-add modular multiply, msb first
    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, MODULUS}) ? dbl - {1'b0, MODULUS} : dbl;
        add_sum = dbl_red + (exp_reg[bit_reg] ? {1'b0, prod_reg} : '0);
        if (add_sum >= {1'b0, MODULUS})
        begin
            add_sum = add_sum - {1'b0, MODULUS};
        end
        acc_next = add_sum[RES_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            i_reg       <= CNT_W'(2);
            j_reg       <= '0;
            p_reg       <= '0;
            limit_reg   <= '0;
            div_cnt_reg <= '0;
            bit_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.res_load;
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.sv_inc_i)
            begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.sv_load_j)
            begin
                j_reg <= sq[CNT_W-1:0];
            end
            else if (cmd.sv_mark)
            begin
                j_reg <= j_reg + i_reg;
            end
            if (cmd.it_load)
            begin
                p_reg     <= CNT_W'(2);
                limit_reg <= (n_ext < MAX_C) ? n_ext : MAX_C;
            end
            else if (cmd.p_inc)
            begin
                p_reg <= p_reg + 1'b1;
            end
            if (cmd.div_load)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.mul_load)
            begin
                bit_reg <= 4'd15;
            end
            else if (cmd.mul_step)
            begin
                bit_reg <= bit_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.it_load)
        begin
            n_reg    <= n_value;
            prod_reg <= RES_W'(1);
        end
        else if (cmd.mul_step && bit_reg == 4'd0)
        begin
            prod_reg <= acc_next;
        end
        if (cmd.exp_init)
        begin
            m_reg   <= n_reg;
            exp_reg <= N_W'(1);
        end
        else if (cmd.exp_add)
        begin
            exp_reg <= exp_reg + m_reg;
        end
        else if (cmd.div_step)
        begin
            m_reg <= {m_reg[N_W-2:0], ge};
        end
        if (cmd.div_load)
        begin
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? rem_sh - p_ext : rem_sh;
        end
        if (cmd.mul_load)
        begin
            acc_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.res_load)
        begin
            count_reg <= prod_reg;
        end
    end

    assign status.clr_last = (clr_cnt_reg == MAX_C);
    assign status.sv_done  = (sq > MAX_SQ);
    assign status.flag     = rd_data_reg;
    assign status.j_over   = (j_reg > MAX_C);
    assign status.p_over   = (p_reg > limit_reg);
    assign status.div_last = (div_cnt_reg == 4'd15);
    assign status.m_zero   = (m_reg == '0);
    assign status.mul_last = (bit_reg == 4'd0);

    assign done          = done_reg;
    assign divisor_count = count_reg;

endmodule

// File: rtl/factorial_divisor_count_mod_prime.sv
// top level of the factorial divisor count block
//
// a word n_value is taken at a rising edge with start high and busy low;
// busy stays high until the result is under way and then drops
// one result word per item: divisor_count, the divisor count of n! modulo
// 1000000007, shown for exactly one cycle with done high; the receiver
// cannot stall, so done is a plain strobe
// after reset the flag memory is cleared, addresses 0 to MAX_N, then sieved
// (each candidate up to sqrt(MAX_N) is read and checked, and for each prime
// its multiples from its square up to MAX_N are marked); busy is high
// throughout and no word is taken
// per item: each candidate p up to min(n, MAX_N) is read from the flag
// memory and checked; for each prime, divisions n/p^k (16-step restoring
// divider) build exponent + 1, which the shift-add modular multiply folds
// into the product, then the result is delivered; n of 0 or 1 gives 1
// for n = 65535 the run time is dominated by the divider
// the next word can be taken in the cycle that done is shown
module factorial_divisor_count_mod_prime #(
    parameter int MAX_N = fdcmp_pkg::DEFAULT_MAX_N
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [fdcmp_pkg::N_W-1:0]    n_value,
    output logic                         done,
    output logic [fdcmp_pkg::RES_W-1:0]  divisor_count
);
    import fdcmp_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: reset clear, sieve, then the per-item prime walk
    fdcmp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // flag memory, divider and modular multiplier
    fdcmp_dp #(
        .MAX_N (MAX_N)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .n_value       (n_value),
        .done          (done),
        .divisor_count (divisor_count)
    );

endmodule

// File: rtl/fdcmp_checker.sv
// port-level checks for the factorial divisor count block, with bind
module fdcmp_props (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [fdcmp_pkg::RES_W-1:0]  divisor_count
);
    import fdcmp_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted word");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (divisor_count < MODULUS))
        else $error("result not reduced");

endmodule

bind factorial_divisor_count_mod_prime fdcmp_props u_fdcmp_props (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .divisor_count (divisor_count)
);

// File: sim/fdcmp_checker.sv
// result predictor and scoreboard for the factorial divisor count block
module fdcmp_checker #(
    parameter int MAX_N = fdcmp_pkg::DEFAULT_MAX_N
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [fdcmp_pkg::N_W-1:0]    n_value,
    input  logic                         done,
    input  logic [fdcmp_pkg::RES_W-1:0]  divisor_count,
    output int                           fail_count,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import fdcmp_pkg::*;

    bit               is_prime [0:MAX_N];
    logic [RES_W-1:0] expect_mem [0:255];
    logic [7:0]       wr_ptr;
    logic [7:0]       rd_ptr;

    // own sieve of eratosthenes over 0..MAX_N
    initial
    begin
        for (int i = 0; i <= MAX_N; i++)
            is_prime[i] = (i >= 2);
        for (int i = 2; i * i <= MAX_N; i++)
            if (is_prime[i])
                for (int j = i * i; j <= MAX_N; j += i)
                    is_prime[j] = 0;
    end

    // legendre exponents, product of (exponent + 1) modulo MODULUS
    function automatic logic [RES_W-1:0] divisors_of_factorial(input logic [N_W-1:0] n);
        longint prod;
        int     top;
        int     e;
        int     m;
        prod = 1;
        top  = (int'(n) < MAX_N) ? int'(n) : MAX_N;
        for (int p = 2; p <= top; p++)
        begin
            if (!is_prime[p])
                continue;
            e = 1;
            for (m = int'(n) / p; m > 0; m = m / p)
                e += m;
            prod = (prod * e) % longint'(MODULUS);
        end
        return prod[RES_W-1:0];
    endfunction

    assign pending = int'(8'(wr_ptr - rd_ptr));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            wr_ptr     <= '0;
            rd_ptr     <= '0;
        end
        else
        begin
            if (done)
            begin
                if (wr_ptr == rd_ptr)
                begin
                    $display("%0t: unexpected word, expected none, actual %0d",
                             $time, divisor_count);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (expect_mem[rd_ptr] !== divisor_count)
                    begin
                        $display("%0t: divisor_count mismatch, expected %0d, actual %0d",
                                 $time, expect_mem[rd_ptr], divisor_count);
                        fail_count <= fail_count + 1;
                    end
                    rd_ptr <= rd_ptr + 8'd1;
                end
            end
            if (start && !busy)
            begin
                expect_mem[wr_ptr] <= divisors_of_factorial(n_value);
                wr_ptr             <= wr_ptr + 8'd1;
            end
        end
    end

endmodule

// File: sim/testbench.sv
// stimulus, watchdog and verdict for the factorial divisor count block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fdcmp_pkg::*;

    // watchdog covers the clearing pass and sieve, and the longest item, n = 65535
    localparam int IDLE_LIMIT = 2000000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [N_W-1:0]   n_value;
    logic             done;
    logic [RES_W-1:0] divisor_count;
    int               fail_count;
    int               pending;
    int               idle_cycles = 0;
    bit               burst_mode;

    factorial_divisor_count_mod_prime u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .n_value       (n_value),
        .done          (done),
        .divisor_count (divisor_count)
    );

    fdcmp_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .n_value       (n_value),
        .done          (done),
        .divisor_count (divisor_count),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // no-progress watchdog: any accepted word or shown result resets it
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // offer one word after a random gap, or none in burst mode; start stays high across a zero gap
    task automatic send_n(input logic [N_W-1:0] n);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        n_value <= n;
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        burst_mode  = 0;
        rst_n       = 0;
        start       = 0;
        n_value     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: small n giving 1, first primes, powers of two, full width
        send_n(16'd0);
        send_n(16'd1);
        send_n(16'd2);
        send_n(16'd3);
        send_n(16'd4);
        send_n(16'd5);
        send_n(16'd6);
        send_n(16'd7);
        send_n(16'd8);
        send_n(16'd11);
        send_n(16'd12);
        send_n(16'd16);
        send_n(16'd25);
        send_n(16'd97);
        send_n(16'd128);
        send_n(16'd255);
        send_n(16'd256);
        send_n(16'd1024);
        // widest n: every prime in the table walked, every input bit high
        send_n(16'hFFFF);

        // random: mostly small n to keep the run short, some medium
        for (int k = 0; k < 80; k++)
        begin
            if (k % 20 == 0)
                burst_mode = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 14) == 0)
                send_n(16'($urandom_range(0, 4000)));
            else
                send_n(16'($urandom_range(0, 300)));
        end
        start <= 1'b0;
        @(posedge clk);

        // drain, then allow for any trailing strobe
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
